[hdl/lbfs_pkg.sv]
// Shared types, codes and constants of the line buffer field splitter.
package lbfs_pkg;

    localparam int LINE_BYTES_DEF  = 64;
    localparam int MAX_RECORDS_DEF = 16;
    localparam int MAX_FIELDS_DEF  = 8;
    localparam int FIELD_CHARS_DEF = 16;

    localparam int FILL_W = 7;
    localparam int CMP_W  = 9;
    localparam int REC_W  = 16;
    localparam int PROD_W = 19;

    localparam logic [REC_W-1:0] MAG_SAT = 16'd32768;
    localparam logic [REC_W-1:0] POS_MAX = 16'd32767;

    localparam logic [1:0] ACT_RECV  = 2'd0;
    localparam logic [1:0] ACT_CLEAR = 2'd1;
    localparam logic [1:0] ACT_SPLIT = 2'd2;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_EVAL,
        S_STATUS
    } lbfs_state_t;

    typedef enum logic [1:0] {
        PH_SKIP,
        PH_DIGITS,
        PH_STOP
    } lbfs_phase_t;

    typedef struct packed {
        lbfs_phase_t       phase;
        logic              neg;
        logic [REC_W-1:0]  mag;
    } lbfs_parse_t;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] byte_value;
    } lbfs_cmd_t;

    typedef struct packed {
        logic              write_valid;
        logic [3:0]        record_id;
        logic [2:0]        field_index;
        logic [3:0]        char_pos;
        logic [7:0]        char_value;
        logic              out_of_range;
        logic              line_ready;
        logic [FILL_W-1:0] fill_level;
        logic              last;
    } lbfs_rsp_t;

endpackage

[hdl/line_buffer_field_splitter_top.sv]
// Top level of the line buffer field splitter: sequencer, counters and result register.
//
// Receive and clear requests, and any other request that is not a split, each give one
// status result. A split request walks the stored line byte by byte (a registered read of
// the line store, then one pass through the shared parse and count logic), and a byte
// that gives a result waits while the result side stalls; the block takes no request
// during a split. Each field character other than a semicolon gives one result,
// suppressed writes give a flagged result, and the split closes with a status result
// marked last. The line store needs no clearing after reset.
module line_buffer_field_splitter_top import lbfs_pkg::*; #(
    parameter int LINE_BYTES  = LINE_BYTES_DEF,
    parameter int MAX_RECORDS = MAX_RECORDS_DEF,
    parameter int MAX_FIELDS  = MAX_FIELDS_DEF,
    parameter int FIELD_CHARS = FIELD_CHARS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    output logic       cmd_ready,
    input  lbfs_cmd_t  cmd,
    output logic       rsp_valid,
    input  logic       rsp_ready,
    output lbfs_rsp_t  rsp
);

    localparam int ADDR_W = $clog2(LINE_BYTES);

    lbfs_state_t       state_reg,  state_next;
    logic [FILL_W-1:0] fill_reg,   fill_next;
    logic              done_reg,   done_next;
    logic [REC_W-1:0]  rec_reg,    rec_next;
    logic [FILL_W-1:0] idx_reg,    idx_next;
    logic [FILL_W-1:0] commas_reg, commas_next;
    logic [FILL_W-1:0] pos_reg,    pos_next;
    logic [FILL_W-1:0] fed_reg,    fed_next;
    lbfs_parse_t       parse_reg,  parse_next;
    logic              rsp_valid_reg, rsp_valid_next;
    lbfs_rsp_t         rsp_reg,    rsp_next;
    logic              rsp_load;

    logic              slot_free;
    logic              cmd_fire;
    logic              wr_en;
    logic              rd_en;
    logic [7:0]        ch;
    lbfs_parse_t       parse_step;
    logic [REC_W-1:0]  rec_value;
    logic [FILL_W-1:0] fld;
    logic              bad;

    lbfs_store #(
        .DEPTH (LINE_BYTES)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (fill_reg[ADDR_W-1:0]),
        .wr_data (cmd.byte_value),
        .rd_en   (rd_en),
        .rd_addr (idx_reg[ADDR_W-1:0]),
        .rd_data (ch)
    );

    lbfs_numparse u_numparse (
        .cur       (parse_reg),
        .ch        (ch),
        .nxt       (parse_step),
        .rec_value (rec_value)
    );

    assign slot_free = !rsp_valid_reg || rsp_ready;
    assign cmd_ready = (state_reg == S_IDLE) && slot_free;
    assign cmd_fire  = cmd_valid && cmd_ready;

    assign wr_en = cmd_fire && (cmd.action == ACT_RECV)
                   && (fill_reg < FILL_W'(LINE_BYTES))
                   && (cmd.byte_value != CH_CR) && (cmd.byte_value != CH_LF)
                   && (cmd.byte_value != CH_BS);

    assign fld = commas_reg - FILL_W'(1);
    assign bad = rec_reg[REC_W-1]
                 || (rec_reg >= REC_W'(MAX_RECORDS))
                 || (fld >= FILL_W'(MAX_FIELDS))
                 || ({2'b00, pos_reg} >= CMP_W'(FIELD_CHARS));

    always_comb
    begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        done_next   = done_reg;
        rec_next    = rec_reg;
        idx_next    = idx_reg;
        commas_next = commas_reg;
        pos_next    = pos_reg;
        fed_next    = fed_reg;
        parse_next  = parse_reg;
        rd_en       = 1'b0;
        rsp_load    = 1'b0;
        rsp_next    = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_fire)
                begin
                    case (cmd.action)
                        ACT_RECV:
                        begin
                            if (fill_reg < FILL_W'(LINE_BYTES))
                            begin
                                if ((cmd.byte_value == CH_CR) || (cmd.byte_value == CH_LF))
                                begin
                                    done_next = 1'b1;
                                end
                                else if (cmd.byte_value == CH_BS)
                                begin
                                    if (fill_reg != '0)
                                    begin
                                        fill_next = fill_reg - FILL_W'(1);
                                    end
                                end
                                else
                                begin
                                    fill_next = fill_reg + FILL_W'(1);
                                end
                            end
                        end
                        ACT_CLEAR:
                        begin
                            done_next = 1'b0;
                            fill_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase

                    if (cmd.action == ACT_SPLIT)
                    begin
                        idx_next     = '0;
                        commas_next  = '0;
                        pos_next     = '0;
                        fed_next     = '0;
                        parse_next   = '{phase: PH_SKIP, neg: 1'b0, mag: '0};
                        state_next   = S_FETCH;
                    end
                    else
                    begin
                        rsp_load            = 1'b1;
                        rsp_next.line_ready = done_next;
                        rsp_next.fill_level = fill_next;
                        rsp_next.last       = 1'b1;
                    end
                end
            end
            S_FETCH:
            begin
                if (idx_reg < fill_reg)
                begin
                    rd_en      = 1'b1;
                    state_next = S_EVAL;
                end
                else
                begin
                    state_next = S_STATUS;
                end
            end
            S_EVAL:
            begin
                if (ch == CH_COMMA)
                begin
                    commas_next = commas_reg + FILL_W'(1);
                    if (commas_reg == '0)
                    begin
                        rec_next = rec_value;
                    end
                    pos_next   = '0;
                    idx_next   = idx_reg + FILL_W'(1);
                    state_next = S_FETCH;
                end
                else if (commas_reg == '0)
                begin
                    if ((ch != CH_COLON)
                        && (({2'b00, fed_reg} + CMP_W'(1)) < CMP_W'(FIELD_CHARS)))
                    begin
                        fed_next   = fed_reg + FILL_W'(1);
                        parse_next = parse_step;
                    end
                    idx_next   = idx_reg + FILL_W'(1);
                    state_next = S_FETCH;
                end
                else if (ch != CH_SEMI)
                begin
                    if (slot_free)
                    begin
                        rsp_load            = 1'b1;
                        rsp_next.line_ready = done_reg;
                        rsp_next.fill_level = fill_reg;
                        if (bad)
                        begin
                            rsp_next.out_of_range = 1'b1;
                        end
                        else
                        begin
                            rsp_next.write_valid = 1'b1;
                            rsp_next.record_id   = rec_reg[3:0];
                            rsp_next.field_index = fld[2:0];
                            rsp_next.char_pos    = pos_reg[3:0];
                            rsp_next.char_value  = ch;
                        end
                        pos_next   = pos_reg + FILL_W'(1);
                        idx_next   = idx_reg + FILL_W'(1);
                        state_next = S_FETCH;
                    end
                end
                else
                begin
                    idx_next   = idx_reg + FILL_W'(1);
                    state_next = S_FETCH;
                end
            end
            S_STATUS:
            begin
                if (slot_free)
                begin
                    rsp_load            = 1'b1;
                    rsp_next.line_ready = done_reg;
                    rsp_next.fill_level = fill_reg;
                    rsp_next.last       = 1'b1;
                    state_next          = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign rsp_valid_next = rsp_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            done_reg      <= 1'b0;
            rec_reg       <= '0;
            idx_reg       <= '0;
            commas_reg    <= '0;
            pos_reg       <= '0;
            fed_reg       <= '0;
            parse_reg     <= '{phase: PH_SKIP, neg: 1'b0, mag: '0};
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            done_reg      <= done_next;
            rec_reg       <= rec_next;
            idx_reg       <= idx_next;
            commas_reg    <= commas_next;
            pos_reg       <= pos_next;
            fed_reg       <= fed_next;
            parse_reg     <= parse_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rsp_load)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(LINE_BYTES))
        else $error("line store fill beyond depth");

    a_write_not_flagged: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> !(rsp_reg.write_valid && rsp_reg.out_of_range))
        else $error("write result also flagged out of range");

    a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_reg.last) |-> (!rsp_reg.write_valid && !rsp_reg.out_of_range))
        else $error("status result carries a write");

    a_split_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_fire && (cmd.action == ACT_SPLIT)) |=> (state_reg == S_FETCH))
        else $error("split request did not start the walk");

    a_fill_stable_split: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |=> $stable(fill_reg))
        else $error("fill level changed during split");

endmodule

[hdl/lbfs_store.sv]
// Line store: single write port, one registered read port.
module lbfs_store import lbfs_pkg::*; #(
    parameter int DEPTH = LINE_BYTES_DEF
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [7:0]               wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [7:0]               rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hdl/lbfs_numparse.sv]
// Record number parse step: one character into the atoi-style accumulator.
module lbfs_numparse import lbfs_pkg::*; (
    input  lbfs_parse_t      cur,
    input  logic [7:0]       ch,
    output lbfs_parse_t      nxt,
    output logic [REC_W-1:0] rec_value
);

    logic              is_digit;
    logic              is_space;
    logic              is_sign;
    logic [3:0]        digit;
    logic [PROD_W-1:0] acc;

    assign is_digit = ch inside {[CH_ZERO:CH_NINE]};
    assign is_space = (ch == CH_SPACE) || (ch inside {[CH_TAB:CH_CR]});
    assign is_sign  = (ch == CH_PLUS) || (ch == CH_MINUS);
    assign digit    = 4'(ch - CH_ZERO);

    // mag * 10 + digit
    assign acc = (PROD_W'(cur.mag) << 3) + (PROD_W'(cur.mag) << 1) + PROD_W'(digit);

    always_comb
    begin
        nxt = cur;
        case (cur.phase)
            PH_SKIP:
            begin
                if (is_space)
                begin
                    nxt.phase = PH_SKIP;
                end
                else if (is_sign)
                begin
                    nxt.neg   = (ch == CH_MINUS);
                    nxt.phase = PH_DIGITS;
                end
                else if (is_digit)
                begin
                    nxt.mag   = REC_W'(digit);
                    nxt.phase = PH_DIGITS;
                end
                else
                begin
                    nxt.phase = PH_STOP;
                end
            end
            PH_DIGITS:
            begin
                if (is_digit)
                begin
                    nxt.mag = (acc > PROD_W'(MAG_SAT)) ? MAG_SAT : acc[REC_W-1:0];
                end
                else
                begin
                    nxt.phase = PH_STOP;
                end
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

    assign rec_value = cur.neg ? (REC_W'(0) - cur.mag)
                               : ((cur.mag > POS_MAX) ? POS_MAX : cur.mag);

endmodule

[dv/tb.sv]
// Testbench of the line buffer field splitter: random line traffic, prediction and result check.
module tb import lbfs_pkg::*; ();

    localparam logic [1:0] ACT_NONE = 2'd3;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam int ITEM_TARGET      = 380;
    localparam int CYCLE_LIMIT      = 2000000;
    localparam int MAX_WRITES       = 63;

    class line_split_scoreboard;
        logic [7:0]  store_bytes [LINE_BYTES_DEF] = '{default: 8'h00};
        int          fill = 0;
        bit          ready_flag = 0;
        logic [15:0] rec_num = 16'h0000;
        lbfs_rsp_t   expected_q [$];
        int          mismatches = 0;
        int          checked = 0;
        int          requests = 0;
        int          splits = 0;
        int          flagged = 0;
        int          most_results = 0;

        function lbfs_rsp_t status_rsp();
            lbfs_rsp_t r;
            r = '0;
            r.line_ready = ready_flag;
            r.fill_level = FILL_W'(fill);
            r.last = 1'b1;
            return r;
        endfunction

        function void predict_split();
            int          commas = 0;
            int          pos = 0;
            int          fed = 0;
            int          n = 0;
            int          mag = 0;
            int          fld;
            bit          neg = 0;
            bit          bad;
            lbfs_phase_t phase = PH_SKIP;
            logic [7:0]  c;
            lbfs_rsp_t   r;
            for (int i = 0; i < fill; i++)
            begin
                c = store_bytes[i];
                if (c == CH_COMMA)
                begin
                    commas++;
                    if (commas == 1)
                        rec_num = neg ? 16'(65536 - mag) : ((mag > 32767) ? 16'd32767 : 16'(mag));
                    pos = 0;
                end
                else if (commas == 0)
                begin
                    if (c != CH_COLON && fed + 1 < FIELD_CHARS_DEF)
                    begin
                        fed++;
                        if (phase == PH_SKIP)
                        begin
                            if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))
                                phase = PH_SKIP;
                            else if (c == CH_PLUS || c == CH_MINUS)
                            begin
                                neg = (c == CH_MINUS);
                                phase = PH_DIGITS;
                            end
                            else if (c >= CH_ZERO && c <= CH_NINE)
                            begin
                                mag = c - CH_ZERO;
                                phase = PH_DIGITS;
                            end
                            else
                                phase = PH_STOP;
                        end
                        else if (phase == PH_DIGITS)
                        begin
                            if (c >= CH_ZERO && c <= CH_NINE)
                            begin
                                mag = mag * 10 + (c - CH_ZERO);
                                if (mag > 32768)
                                    mag = 32768;
                            end
                            else
                                phase = PH_STOP;
                        end
                    end
                end
                else if (c != CH_SEMI)
                begin
                    fld = commas - 1;
                    bad = rec_num[15] || rec_num >= MAX_RECORDS_DEF
                          || fld >= MAX_FIELDS_DEF || pos >= FIELD_CHARS_DEF;
                    if (n < MAX_WRITES)
                    begin
                        r = status_rsp();
                        r.last = 1'b0;
                        if (bad)
                        begin
                            r.out_of_range = 1'b1;
                            flagged++;
                        end
                        else
                        begin
                            r.write_valid = 1'b1;
                            r.record_id   = rec_num[3:0];
                            r.field_index = fld[2:0];
                            r.char_pos    = pos[3:0];
                            r.char_value  = c;
                        end
                        expected_q.push_back(r);
                        n++;
                    end
                    pos++;
                end
            end
            expected_q.push_back(status_rsp());
            if (n + 1 > most_results)
                most_results = n + 1;
        endfunction

        function void note_request(lbfs_cmd_t req);
            requests++;
            case (req.action)
                ACT_RECV:
                begin
                    if (fill < LINE_BYTES_DEF)
                    begin
                        if (req.byte_value == CH_CR || req.byte_value == CH_LF)
                            ready_flag = 1;
                        else if (req.byte_value == CH_BS)
                        begin
                            if (fill > 0)
                            begin
                                fill--;
                                store_bytes[fill] = 8'h00;
                            end
                        end
                        else
                        begin
                            store_bytes[fill] = req.byte_value;
                            fill++;
                        end
                    end
                    expected_q.push_back(status_rsp());
                end
                ACT_CLEAR:
                begin
                    ready_flag = 0;
                    fill = 0;
                    store_bytes = '{default: 8'h00};
                    expected_q.push_back(status_rsp());
                end
                ACT_SPLIT:
                begin
                    splits++;
                    predict_split();
                end
                default:
                    expected_q.push_back(status_rsp());
            endcase
        endfunction

        function void report_field(string name, int want, int got);
            if (want != got)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d: %s expected %0d, got %0d", checked, name, want, got);
            end
        endfunction

        function void check_result(lbfs_rsp_t got);
            lbfs_rsp_t want;
            checked++;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d: none pending, got %h", checked, got);
                return;
            end
            want = expected_q.pop_front();
            report_field("write_valid", want.write_valid, got.write_valid);
            report_field("record_id", want.record_id, got.record_id);
            report_field("field_index", want.field_index, got.field_index);
            report_field("char_pos", want.char_pos, got.char_pos);
            report_field("char_value", want.char_value, got.char_value);
            report_field("out_of_range", want.out_of_range, got.out_of_range);
            report_field("line_ready", want.line_ready, got.line_ready);
            report_field("fill_level", want.fill_level, got.fill_level);
            report_field("last", want.last, got.last);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      cmd_valid = 1'b0;
    logic      cmd_ready;
    lbfs_cmd_t cmd = '0;
    logic      rsp_valid;
    logic      rsp_ready = 1'b0;
    lbfs_rsp_t rsp;

    line_split_scoreboard sb;
    logic [7:0] line_q [$];
    logic [7:0] blanks [4] = '{CH_SPACE, CH_TAB, CH_VT, CH_FF};
    int drv_fill = 0;
    int items_sent = 0;
    int cmd_idle_pct = 0;
    int rsp_idle_pct = 0;
    int stall_left = 0;
    int cycle_count = 0;
    bit full_done = 0;
    bit calm = 0;

    line_buffer_field_splitter_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cmd_valid && cmd_ready)
                sb.note_request(cmd);
            if (rsp_valid && rsp_ready)
                sb.check_result(rsp);
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left != 0)
        begin
            rsp_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (rsp_idle_pct != 0 && $urandom_range(1, 100) <= rsp_idle_pct)
        begin
            rsp_ready <= 1'b0;
            stall_left <= $urandom_range(0, 17);
        end
        else
            rsp_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic logic [7:0] field_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (c == CH_CR || c == CH_LF || c == CH_BS || c == CH_COMMA);
        return c;
    endfunction

    task automatic send_request(logic [1:0] act, logic [7:0] val);
        lbfs_cmd_t req;
        req.action = act;
        req.byte_value = val;
        if (!(act == ACT_RECV && drv_fill >= LINE_BYTES_DEF))
            items_sent++;
        if (act == ACT_CLEAR)
            drv_fill = 0;
        else if (act == ACT_RECV && drv_fill < LINE_BYTES_DEF && val != CH_CR && val != CH_LF)
            drv_fill = (val != CH_BS) ? drv_fill + 1 : ((drv_fill > 0) ? drv_fill - 1 : 0);
        if (cmd_idle_pct != 0 && $urandom_range(1, 100) <= cmd_idle_pct)
        begin
            cmd_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd <= req;
        do
            @(posedge clk);
        while (!cmd_ready);
    endtask

    task automatic send_text(string s);
        foreach (s[i])
            send_request(ACT_RECV, s[i]);
    endtask

    task automatic random_line();
        int kind;
        int nf;
        int flen;
        string digits;
        kind = $urandom_range(0, 99);
        line_q.delete();
        if (kind < 12)
        begin
            repeat ($urandom_range(1, 10))
                send_request(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            return;
        end
        if (kind < 15 || (!full_done && items_sent >= 150))
        begin
            full_done = 1;
            send_request(ACT_CLEAR, 8'h00);
            while (drv_fill < LINE_BYTES_DEF)
                send_request(ACT_RECV, ($urandom_range(0, 7) == 0) ? CH_COMMA : field_char());
            send_request(ACT_RECV, CH_CR);
            send_request(ACT_RECV, CH_BS);
            send_request(ACT_RECV, field_char());
            send_request(ACT_SPLIT, 8'($urandom_range(0, 255)));
            send_request(ACT_CLEAR, 8'($urandom_range(0, 255)));
            return;
        end
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) line_q.push_back(blanks[$urandom_range(0, 3)]);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4:
            begin
                if ($urandom_range(0, 3) == 0)
                    line_q.push_back(CH_PLUS);
                digits = $sformatf("%0d", $urandom_range(0, 19));
            end
            5:
            begin
                line_q.push_back(CH_MINUS);
                digits = $sformatf("%0d", $urandom_range(0, 40000));
            end
            6:
            begin
                if ($urandom_range(0, 1) == 0)
                    line_q.push_back(CH_MINUS);
                digits = $sformatf("%0d", $urandom_range(32700, 999999));
            end
            7:
            begin
                repeat ($urandom_range(12, 17)) line_q.push_back(CH_ZERO);
                digits = $sformatf("%0d", $urandom_range(1, 9));
            end
            8:
            begin
                line_q.push_back(field_char());
                digits = $sformatf("%0d", $urandom_range(0, 99));
            end
            default:
                digits = "";
        endcase
        foreach (digits[i])
            line_q.push_back(digits[i]);
        if ($urandom_range(0, 2) == 0)
            line_q.insert($urandom_range(0, line_q.size()), CH_COLON);
        // lines without a comma leave the record number untouched
        if (kind >= 25)
            line_q.push_back(CH_COMMA);
        nf = ($urandom_range(0, 5) == 0) ? $urandom_range(7, 10) : $urandom_range(1, 3);
        for (int f = 0; f < nf; f++)
        begin
            if (f > 0 && kind >= 25)
                line_q.push_back(CH_COMMA);
            flen = ($urandom_range(0, 5) == 0) ? $urandom_range(14, 18) : $urandom_range(0, 4);
            repeat (flen)
                line_q.push_back(($urandom_range(0, 4) == 0) ? CH_SEMI : field_char());
        end
        while (line_q.size() > LINE_BYTES_DEF - 1)
            void'(line_q.pop_back());
        if (drv_fill + line_q.size() > LINE_BYTES_DEF)
            send_request(ACT_CLEAR, 8'($urandom_range(0, 255)));
        foreach (line_q[i])
        begin
            if ($urandom_range(0, 11) == 0)
            begin
                send_request(ACT_RECV, field_char());
                send_request(ACT_RECV, CH_BS);
            end
            send_request(ACT_RECV, line_q[i]);
        end
        case ($urandom_range(0, 5))
            0: ;
            1, 2: send_request(ACT_RECV, CH_CR);
            default: send_request(ACT_RECV, CH_LF);
        endcase
        send_request(ACT_SPLIT, 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 3) != 0)
            send_request(ACT_CLEAR, 8'($urandom_range(0, 255)));
    endtask

    initial
    begin
        sb = new;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        send_request(ACT_SPLIT, 8'h00);
        send_request(ACT_NONE, 8'hFF);
        send_request(ACT_RECV, CH_BS);
        send_request(ACT_RECV, CH_LF);
        send_request(ACT_RECV, 8'h00);
        send_request(ACT_CLEAR, 8'hFF);
        send_text("-1,a");
        send_request(ACT_RECV, CH_CR);
        send_request(ACT_SPLIT, 8'h00);
        send_request(ACT_CLEAR, 8'h00);
        send_text("+1:2,,x;y");
        send_request(ACT_SPLIT, 8'hFF);
        send_request(ACT_CLEAR, 8'h00);

        while (items_sent < ITEM_TARGET)
        begin
            calm = (items_sent >= ITEM_TARGET - 40);
            cmd_idle_pct = (calm || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
            rsp_idle_pct = (calm || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
            random_line();
        end
        cmd_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Checked %0d results from %0d requests, %0d of them line splits.",
                 sb.checked, sb.requests, sb.splits);
        $display("Suppressed writes seen: %0d; largest split produced %0d results.",
                 sb.flagged, sb.most_results);
        if (sb.mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

[files.f]
hdl/lbfs_pkg.sv
hdl/lbfs_store.sv
hdl/lbfs_numparse.sv
hdl/line_buffer_field_splitter_top.sv
dv/tb.sv
